// ===== hw/rtl/pp_pkg.sv =====
package pp_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int SPAWN_CAP_DEF = 16;

    // width of max_live and of the slot counters that must hold the slot count itself
    localparam int CNT_W = 7;
    localparam int CFG_IDX_W = 4;

    localparam logic [31:0] LFSR_SEED = 32'hACE1_ACE1;
    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_LIVE   = 4'd0,
        REG_SPAWN_LIFE = 4'd1,
        REG_RANGE_X    = 4'd2,
        REG_RANGE_Y    = 4'd3,
        REG_RANGE_Z    = 4'd4,
        REG_SPEED_X    = 4'd5,
        REG_SPEED_Y    = 4'd6,
        REG_SPEED_Z    = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        life;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_slot_data;

endpackage

// ===== hw/rtl/particle_pool_update.sv =====
// channel   direction  handshake             payload
// step      in         i_valid / o_stall     i_step_time
// result    out        o_valid / i_stall     o_slot, o_pos_x/y/z, o_valid_res, o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a frame's length grows with n = spawns (<= 16), lim = usable slots and the live slots;
// it is set by the single slot memory write port that the spawn writes and the per-slot
// read-modify-write share
// synchronous active-low reset clears control and the live map and restores register defaults
// a held result stall blocks the walk when a further survivor or the frame end waits behind it
// a new frame is taken once the previous frame's final result sits in the output register
module particle_pool_update #(
    parameter int MAX_SLOTS = pp_pkg::MAX_SLOTS_DEF,
    parameter int SPAWN_CAP = pp_pkg::SPAWN_CAP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [15:0]                    i_step_time,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [5:0]                     o_slot,
    output logic signed [31:0]             o_pos_x,
    output logic signed [31:0]             o_pos_y,
    output logic signed [31:0]             o_pos_z,
    output logic                           o_valid_res,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import pp_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DX, S_DY, S_DZ, S_SX, S_SY, S_SZ, S_SW, S_RD, S_CALC, S_END
    } t_state;

    t_state r_state;

    // configuration
    logic [CNT_W-1:0]   r_max_live;
    logic [15:0]        r_spawn_life, r_range_x, r_range_y, r_range_z;
    logic signed [15:0] r_speed_x, r_speed_y, r_speed_z;

    // frame state
    logic [15:0]        r_t;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic signed [24:0] r_dx, r_dy, r_dz;
    logic [31:0]        r_lfsr;
    logic [IW-1:0]      r_search;
    logic [MAX_SLOTS-1:0] r_alive;
    logic [31:0]        r_prod;
    logic signed [31:0] r_px, r_py;

    // survivor held back until it is known whether it is the last one
    logic               r_hv;
    logic [IW-1:0]      r_h_slot;
    logic signed [31:0] r_h_x, r_h_y, r_h_z;

    // output register
    logic               r_ovalid;
    logic [5:0]         r_o_slot;
    logic signed [31:0] r_o_x, r_o_y, r_o_z;
    logic               r_o_vres, r_o_last;

    // memory
    logic        mem_wr_en, mem_rd_en;
    logic [IW-1:0] mem_wr_addr;
    t_slot_data  mem_wr_data, mem_rd_data;

    // combinational helpers
    logic [CNT_W-1:0]   lim;
    logic [22:0]        n_prod;
    logic [CNT_W-1:0]   n_spawn;
    logic [31:0]        n_lfsr;
    logic [15:0]        draw_u;
    logic [15:0]        draw_r;
    logic [23:0]        spread;
    logic [31:0]        half_r;
    logic [8:0]         age;
    logic               survive;
    logic [15:0]        life_new;
    logic signed [31:0] nx, ny, nz;
    logic               out_free;
    logic               hit1, hit2;
    logic [IW-1:0]      f1, f2;
    logic [IW-1:0]      free_slot;
    logic               free_hit;
    logic signed [16:0] t_s;
    logic signed [15:0] spd;
    logic signed [32:0] dprod;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] p, logic signed [24:0] d);
        logic signed [33:0] s;
        s = 34'(p) + 34'(d);
        if (s > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -34'sh0_8000_0000) begin
            return -32'sh8000_0000;
        end else begin
            return s[31:0];
        end
    endfunction

    assign lim      = (r_max_live > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : r_max_live;
    assign n_prod   = 23'(i_step_time) * 23'(lim);
    assign n_spawn  = (n_prod[22:16] > CNT_W'(SPAWN_CAP)) ? CNT_W'(SPAWN_CAP) : n_prod[22:16];
    assign n_lfsr   = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 32'h0);
    assign draw_u   = n_lfsr[31:16];
    assign spread   = r_prod[31:8];
    assign age      = 9'((17'(r_t) + 17'd128) >> 8);
    assign survive  = mem_rd_data.life > 16'(age);
    assign life_new = mem_rd_data.life - 16'(age);
    assign nx       = sat_add(mem_rd_data.x, r_dx);
    assign ny       = sat_add(mem_rd_data.y, r_dy);
    assign nz       = sat_add(mem_rd_data.z, r_dz);
    assign out_free = !r_ovalid || !i_stall;
    assign t_s      = $signed({1'b0, r_t});

    // range and speed for the axis being worked this cycle
    always_comb begin
        unique case (r_state)
            S_SY:    draw_r = r_range_y;
            S_SZ:    draw_r = r_range_z;
            default: draw_r = r_range_x;
        endcase
        unique case (r_state)
            S_DY:    spd = r_speed_y;
            S_DZ:    spd = r_speed_z;
            default: spd = r_speed_x;
        endcase
    end
    assign dprod  = 33'(spd) * 33'(t_s);
    assign half_r = {9'b0, r_range_z, 7'b0};

    // round-robin free slot search over the live map
    always_comb begin
        hit1 = 1'b0;
        hit2 = 1'b0;
        f1   = '0;
        f2   = '0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (!r_alive[k] && CNT_W'(k) < lim && IW'(k) >= r_search) begin
                hit1 = 1'b1;
                f1   = IW'(k);
            end
            if (!r_alive[k] && CNT_W'(k) < lim && IW'(k) < r_search) begin
                hit2 = 1'b1;
                f2   = IW'(k);
            end
        end
        free_hit  = hit1 || hit2;
        free_slot = hit1 ? f1 : (hit2 ? f2 : '0);
    end

    // memory access
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = free_slot;
        mem_wr_data = '{life: r_spawn_life, x: r_px, y: r_py,
                        z: $signed(half_r - {8'b0, spread})};
        mem_rd_en   = (r_state == S_RD) && (r_idx < lim) && r_alive[r_idx[IW-1:0]];
        if (r_state == S_SW) begin
            mem_wr_en = 1'b1;
        end else if (r_state == S_CALC && survive && (!r_hv || out_free)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_idx[IW-1:0];
            mem_wr_data = '{life: life_new, x: nx, y: ny, z: nz};
        end
    end

    pp_mem #(
        .DEPTH (MAX_SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_live   <= CNT_W'(64);
            r_spawn_life <= 16'd256;
            r_range_x    <= 16'd256;
            r_range_y    <= 16'd256;
            r_range_z    <= 16'd256;
            r_speed_x    <= '0;
            r_speed_y    <= '0;
            r_speed_z    <= '0;
            r_lfsr       <= LFSR_SEED;
            r_search     <= '0;
            r_alive      <= '0;
            r_hv         <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            // configuration write, only while idle
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MAX_LIVE:   r_max_live   <= i_cfg_data[CNT_W-1:0];
                    REG_SPAWN_LIFE: r_spawn_life <= i_cfg_data;
                    REG_RANGE_X:    r_range_x    <= i_cfg_data;
                    REG_RANGE_Y:    r_range_y    <= i_cfg_data;
                    REG_RANGE_Z:    r_range_z    <= i_cfg_data;
                    REG_SPEED_X:    r_speed_x    <= $signed(i_cfg_data);
                    REG_SPEED_Y:    r_speed_y    <= $signed(i_cfg_data);
                    REG_SPEED_Z:    r_speed_z    <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_t     <= i_step_time;
                        r_cnt   <= n_spawn;
                        r_state <= S_DX;
                    end
                end
                // per-frame motion step per axis, floor(speed * t / 256)
                S_DX: begin
                    r_dx    <= 25'(dprod >>> 8);
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dy    <= 25'(dprod >>> 8);
                    r_state <= S_DZ;
                end
                S_DZ: begin
                    r_dz  <= 25'(dprod >>> 8);
                    r_idx <= '0;
                    r_state <= (r_cnt != '0) ? S_SX : S_RD;
                end
                // spawn: one draw and one product per axis
                S_SX: begin
                    r_lfsr  <= n_lfsr;
                    r_prod  <= 32'(draw_u) * 32'(draw_r);
                    r_state <= S_SY;
                end
                S_SY: begin
                    r_px    <= $signed({8'b0, spread} - {9'b0, r_range_x, 7'b0});
                    r_lfsr  <= n_lfsr;
                    r_prod  <= 32'(draw_u) * 32'(draw_r);
                    r_state <= S_SZ;
                end
                S_SZ: begin
                    r_py    <= $signed({8'b0, spread});
                    r_lfsr  <= n_lfsr;
                    r_prod  <= 32'(draw_u) * 32'(draw_r);
                    r_state <= S_SW;
                end
                S_SW: begin
                    r_alive[free_slot] <= (r_spawn_life != 16'd0);
                    if (free_hit) begin
                        r_search <= free_slot;
                    end
                    r_cnt   <= r_cnt - CNT_W'(1);
                    r_state <= (r_cnt == CNT_W'(1)) ? S_RD : S_SX;
                end
                // slot walk
                S_RD: begin
                    if (r_idx >= lim) begin
                        r_state <= S_END;
                    end else if (mem_rd_en) begin
                        r_state <= S_CALC;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_CALC: begin
                    if (!survive) begin
                        r_alive[r_idx[IW-1:0]] <= 1'b0;
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_RD;
                    end else if (!r_hv || out_free) begin
                        if (r_hv) begin
                            r_ovalid <= 1'b1;
                            r_o_slot <= 6'(r_h_slot);
                            r_o_x    <= r_h_x;
                            r_o_y    <= r_h_y;
                            r_o_z    <= r_h_z;
                            r_o_vres <= 1'b1;
                            r_o_last <= 1'b0;
                        end
                        r_hv     <= 1'b1;
                        r_h_slot <= r_idx[IW-1:0];
                        r_h_x    <= nx;
                        r_h_y    <= ny;
                        r_h_z    <= nz;
                        r_idx    <= r_idx + CNT_W'(1);
                        r_state  <= S_RD;
                    end
                end
                // final result, or the empty marker when nothing survived
                S_END: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_o_slot <= r_hv ? 6'(r_h_slot) : 6'd0;
                        r_o_x    <= r_hv ? r_h_x : 32'sd0;
                        r_o_y    <= r_hv ? r_h_y : 32'sd0;
                        r_o_z    <= r_hv ? r_h_z : 32'sd0;
                        r_o_vres <= r_hv;
                        r_o_last <= 1'b1;
                        r_hv     <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_slot      = r_o_slot;
    assign o_pos_x     = r_o_x;
    assign o_pos_y     = r_o_y;
    assign o_pos_z     = r_o_z;
    assign o_valid_res = r_o_vres;
    assign o_last      = r_o_last;

endmodule

// ===== hw/rtl/pp_mem.sv =====
module pp_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IW-1:0]      i_wr_addr,
    input  pp_pkg::t_slot_data i_wr_data,
    input  logic               i_rd_en,
    input  logic [IW-1:0]      i_rd_addr,
    output pp_pkg::t_slot_data o_rd_data
);
    import pp_pkg::*;

    t_slot_data r_mem [DEPTH];
    t_slot_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== dv/particle_pool_update_tb.sv =====
module particle_pool_update_tb;
    import pp_pkg::*;

    localparam int NSLOT  = 64;
    localparam int NSPAWN = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [15:0]        i_step_time;
    logic               o_valid;
    logic               i_stall;
    logic [5:0]         o_slot;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;
    logic               o_valid_res;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]        i_cfg_data;

    particle_pool_update i_dut (.*);

    typedef struct packed {
        logic [5:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               vres;
        logic               last;
    } t_particle;

    // predictor state and configuration
    logic [6:0]         pr_max_live;
    logic [15:0]        pr_life_cfg, pr_rx, pr_ry, pr_rz;
    logic signed [15:0] pr_vx, pr_vy, pr_vz;
    logic [15:0]        pr_life [NSLOT];
    logic signed [31:0] pr_px [NSLOT];
    logic signed [31:0] pr_py [NSLOT];
    logic signed [31:0] pr_pz [NSLOT];
    logic [5:0]         pr_search;
    logic [31:0]        pr_lfsr;

    t_particle particle_q [$];
    int  fails;
    int  cycles;
    int  src_idle_pct, snk_idle_pct;
    bit  hold_off;

    // directed frames: step time, and a flag marking the one expected result
    // that can be typed in at a glance (an empty frame)
    typedef struct {
        logic [15:0] t;
        bit          empty_known;
    } t_dir_row;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [15:0] lfsr_draw();
        logic bit0;
        bit0 = pr_lfsr[0];
        pr_lfsr = pr_lfsr >> 1;
        if (bit0) pr_lfsr = pr_lfsr ^ LFSR_TAPS;
        return pr_lfsr[31:16];
    endfunction

    function automatic logic signed [63:0] spread_of(logic [15:0] u, logic [15:0] r);
        logic [63:0] p;
        p = {48'd0, u} * {48'd0, r};
        return $signed(p >> 8);
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] p,
                                                   logic signed [15:0] v,
                                                   logic [15:0] t);
        logic signed [63:0] m, q, s;
        m = 64'(v) * $signed({48'd0, t});
        // floor division by 256 is an arithmetic shift
        q = m >>> 8;
        s = 64'(p) + q;
        if (s > 64'sd2147483647) return 32'sh7fffffff;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic int free_slot(int lim);
        int st;
        st = pr_search;
        for (int i = st; i < lim; i++)
            if (pr_life[i] == 0) begin
                pr_search = 6'(i);
                return i;
            end
        for (int i = 0; i < st && i < lim; i++)
            if (pr_life[i] == 0) begin
                pr_search = 6'(i);
                return i;
            end
        return 0;
    endfunction

    task automatic predict_frame(logic [15:0] t);
        int lim, n, cnt, s;
        logic [16:0] d;
        logic [15:0] ux, uy, uz;
        t_particle r;
        lim = (pr_max_live < NSLOT) ? pr_max_live : NSLOT;
        n   = (int'(t) * lim) >> 16;
        d   = ({1'b0, t} + 17'd128) >> 8;
        cnt = 0;
        if (n > NSPAWN) n = NSPAWN;
        for (int k = 0; k < n; k++) begin
            ux = lfsr_draw();
            uy = lfsr_draw();
            uz = lfsr_draw();
            s = free_slot(lim);
            pr_life[s] = pr_life_cfg;
            pr_px[s] = 32'(spread_of(ux, pr_rx) - 64'(pr_rx) * 128);
            pr_py[s] = 32'(spread_of(uy, pr_ry));
            pr_pz[s] = 32'(64'(pr_rz) * 128 - spread_of(uz, pr_rz));
        end
        for (int i = 0; i < lim; i++) begin
            if (pr_life[i] == 0) continue;
            pr_life[i] = (pr_life[i] > d) ? pr_life[i] - d[15:0] : 16'd0;
            if (pr_life[i] == 0) continue;
            pr_px[i] = sat_add(pr_px[i], pr_vx, t);
            pr_py[i] = sat_add(pr_py[i], pr_vy, t);
            pr_pz[i] = sat_add(pr_pz[i], pr_vz, t);
            r.slot = 6'(i); r.x = pr_px[i]; r.y = pr_py[i]; r.z = pr_pz[i];
            r.vres = 1'b1; r.last = 1'b0;
            particle_q.push_back(r);
            cnt++;
        end
        if (cnt == 0) begin
            r = '0;
            r.last = 1'b1;
            particle_q.push_back(r);
        end else begin
            particle_q[$].last = 1'b1;
        end
    endtask

    // shadow of a register write in the predictor
    task automatic shadow_reg(t_reg_idx idx, logic [15:0] v);
        case (idx)
            REG_MAX_LIVE:   pr_max_live = v[6:0];
            REG_SPAWN_LIFE: pr_life_cfg = v;
            REG_RANGE_X:    pr_rx = v;
            REG_RANGE_Y:    pr_ry = v;
            REG_RANGE_Z:    pr_rz = v;
            REG_SPEED_X:    pr_vx = v;
            REG_SPEED_Y:    pr_vy = v;
            REG_SPEED_Z:    pr_vz = v;
            default: ;
        endcase
    endtask

    task automatic reg_write(t_reg_idx idx, logic [15:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait for the block to drain before touching the registers
    task automatic wait_drained();
        while (particle_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // one frame transfer, with random idle cycles ahead of it
    task automatic send_frame(logic [15:0] t);
        while ($urandom_range(99) < src_idle_pct) @(negedge i_clk);
        i_valid     = 1'b1;
        i_step_time = t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_frame(t);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // random step time, biased towards short steps so that particles live on
    function automatic logic [15:0] rand_step();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom_range(12000));
        endcase
    endfunction

    task automatic rand_regs();
        reg_write(REG_MAX_LIVE, 16'($urandom_range(64)));
        reg_write(REG_SPAWN_LIFE, $urandom_range(3) == 0 ? 16'($urandom)
                                                          : 16'($urandom_range(4000)));
        reg_write(REG_RANGE_X, 16'($urandom));
        reg_write(REG_RANGE_Y, 16'($urandom));
        reg_write(REG_RANGE_Z, 16'($urandom));
        reg_write(REG_SPEED_X, 16'($urandom));
        reg_write(REG_SPEED_Y, 16'($urandom));
        reg_write(REG_SPEED_Z, 16'($urandom));
    endtask

    // result side: random stall, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= hold_off || ($urandom_range(99) < snk_idle_pct);
    end

    // result check against the oldest expected particle
    always @(posedge i_clk) begin
        t_particle e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (particle_q.size() == 0) begin
                $display("%0t: unexpected result slot %0d", $time, o_slot);
                fails++;
            end else begin
                e = particle_q.pop_front();
                if (o_slot !== e.slot || o_pos_x !== e.x || o_pos_y !== e.y
                    || o_pos_z !== e.z || o_valid_res !== e.vres || o_last !== e.last) begin
                    $display("%0t: mismatch expected slot %0d x %h y %h z %h v %b l %b",
                             $time, e.slot, e.x, e.y, e.z, e.vres, e.last);
                    $display("%0t:          actual   slot %0d x %h y %h z %h v %b l %b",
                             $time, o_slot, o_pos_x, o_pos_y, o_pos_z, o_valid_res, o_last);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_dir_row dir_rows [$];
        t_particle e;
        fails = 0; cycles = 0;
        hold_off = 1'b0;
        src_idle_pct = 0; snk_idle_pct = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_step_time = '0; i_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = REG_MAX_LIVE; i_cfg_data = '0;
        pr_max_live = 7'd64; pr_life_cfg = 16'd256;
        pr_rx = 16'd256; pr_ry = 16'd256; pr_rz = 16'd256;
        pr_vx = '0; pr_vy = '0; pr_vz = '0;
        for (int i = 0; i < NSLOT; i++) begin
            pr_life[i] = '0; pr_px[i] = '0; pr_py[i] = '0; pr_pz[i] = '0;
        end
        pr_search = '0;
        pr_lfsr = LFSR_SEED;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero step on an empty pool, full step spawn cap, tiny steps,
        // and a step that kills every particle
        dir_rows = '{'{16'h0000, 1'b1}, '{16'hffff, 1'b0}, '{16'h0001, 1'b0},
                     '{16'h0080, 1'b0}, '{16'h007f, 1'b0}, '{16'hffff, 1'b0},
                     '{16'h0400, 1'b0}, '{16'hffff, 1'b0}, '{16'hffff, 1'b0}};
        foreach (dir_rows[k]) begin
            send_frame(dir_rows[k].t);
            if (dir_rows[k].empty_known) begin
                e = particle_q[$];
                if (e.vres !== 1'b0 || e.last !== 1'b1 || e.slot !== 6'd0) begin
                    $display("%0t: mismatch expected slot 0 v 0 l 1, actual slot %0d v %b l %b",
                             $time, e.slot, e.vres, e.last);
                    fails++;
                end
            end
        end
        wait_drained();

        // extremes: largest speeds, widest spread, all slots, long life
        reg_write(REG_MAX_LIVE, 16'd64);
        reg_write(REG_SPAWN_LIFE, 16'hffff);
        reg_write(REG_RANGE_X, 16'hffff);
        reg_write(REG_RANGE_Y, 16'hffff);
        reg_write(REG_RANGE_Z, 16'hffff);
        reg_write(REG_SPEED_X, 16'h7fff);
        reg_write(REG_SPEED_Y, 16'h8000);
        reg_write(REG_SPEED_Z, 16'hffff);
        for (int k = 0; k < 8; k++) send_frame(16'hffff);
        wait_drained();
        reg_write(REG_SPAWN_LIFE, 16'd0);
        reg_write(REG_MAX_LIVE, 16'd0);
        send_frame(16'hffff);
        wait_drained();
        reg_write(REG_MAX_LIVE, 16'd1);
        reg_write(REG_SPAWN_LIFE, 16'd5);
        reg_write(REG_RANGE_X, 16'd0);
        send_frame(16'hffff);
        send_frame(16'h0000);
        wait_drained();

        // long hold-off on the result side while frames keep arriving
        reg_write(REG_MAX_LIVE, 16'd64);
        reg_write(REG_SPAWN_LIFE, 16'd3000);
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_frame(16'($urandom_range(3000)));
        join
        wait_drained();

        // random phases: sender idles 34 / receiver 67, then swapped, then none
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 67 : 0;
            snk_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 34 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                rand_regs();
                for (int k = 0; k < 10; k++) send_frame(rand_step());
                wait_drained();
            end
        end

        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pp_pkg.sv
hw/rtl/pp_mem.sv
hw/rtl/particle_pool_update.sv
dv/particle_pool_update_tb.sv
